// File: rtl/ulbs_pkg.sv
// Shared types and constants for the UTF-8 literal block sanitizer.
`default_nettype none
package ulbs_pkg;

  localparam int unsigned CpW       = 21;
  localparam int unsigned IndentW   = 6;
  localparam int unsigned RunIdxW   = 6;
  localparam int unsigned CmdDepth  = 4;

  localparam logic [CpW-1:0] CpMax    = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo   = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi   = 21'h00DFFF;
  localparam logic [CpW-1:0] CpLs     = 21'h002028;
  localparam logic [CpW-1:0] CpPs     = 21'h002029;
  localparam logic [CpW-1:0] CpNel    = 21'h000085;
  localparam logic [CpW-1:0] CpTab    = 21'h000009;
  localparam logic [CpW-1:0] CpLf     = 21'h00000A;
  localparam logic [CpW-1:0] CpCr     = 21'h00000D;
  localparam logic [CpW-1:0] CpSpace  = 21'h000020;
  localparam logic [CpW-1:0] CpTilde  = 21'h00007E;
  localparam logic [CpW-1:0] CpNbsp   = 21'h0000A0;
  localparam logic [CpW-1:0] CpBmpLo  = 21'h00D7FF;
  localparam logic [CpW-1:0] CpPriv   = 21'h00E000;
  localparam logic [CpW-1:0] CpBmpHi  = 21'h00FFFD;
  localparam logic [CpW-1:0] Min2     = 21'h000080;
  localparam logic [CpW-1:0] Min3     = 21'h000800;
  localparam logic [CpW-1:0] Min4     = 21'h010000;

  localparam logic [7:0] ByteLf    = 8'h0A;
  localparam logic [7:0] ByteSpace = 8'h20;

  typedef enum logic [1:0] {
    CLASS_NONE = 2'd0,
    CLASS_2B   = 2'd1,
    CLASS_3B   = 2'd2,
    CLASS_4B   = 2'd3
  } ulbs_class_e;

  typedef enum logic {
    KIND_TEXT  = 1'b0,
    KIND_BREAK = 1'b1
  } ulbs_kind_e;

  typedef struct packed {
    ulbs_kind_e      kind;
    logic [1:0]      len_m1;
    logic [3:0][7:0] bytes;
  } ulbs_cmd_t;

endpackage
`default_nettype wire

// File: rtl/ulbs_front.sv
// Front end: UTF-8 decode, validation and line-mode filtering into commands.
`default_nettype none
module ulbs_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         in_byte_i,
  input  wire logic               stream_end_i,
  output ulbs_pkg::ulbs_cmd_t     cmd_o,
  output logic                    cmd_valid_o
);

  logic [ulbs_pkg::CpW-1:0] acc_q, acc_d, acc_ext, dcp, lo;
  logic [1:0]               rem_q, rem_d;
  ulbs_pkg::ulbs_class_e    class_q, class_d;
  logic                     first_q, first_d, first_dec;
  logic                     lead, deliver_en, is_cont;
  logic                     is_break, is_skip, printable;

  assign is_cont = (in_byte_i[7:6] == 2'b10);
  assign acc_ext = {acc_q[ulbs_pkg::CpW-7:0], in_byte_i[5:0]};

  always_comb begin
    unique case (class_q)
      ulbs_pkg::CLASS_2B: lo = ulbs_pkg::Min2;
      ulbs_pkg::CLASS_3B: lo = ulbs_pkg::Min3;
      default:            lo = ulbs_pkg::Min4;
    endcase
  end

  // sequence tracking
  always_comb begin
    acc_d      = acc_q;
    rem_d      = rem_q;
    class_d    = class_q;
    deliver_en = 1'b0;
    dcp        = '0;
    lead       = 1'b1;
    if (rem_q != 2'd0) begin
      if (is_cont) begin
        lead  = 1'b0;
        rem_d = rem_q - 2'd1;
        acc_d = acc_ext;
        if (rem_q == 2'd1) begin
          acc_d   = '0;
          class_d = ulbs_pkg::CLASS_NONE;
          dcp     = acc_ext;
          deliver_en = (acc_ext >= lo) && (acc_ext <= ulbs_pkg::CpMax) &&
                       !((acc_ext >= ulbs_pkg::SurrLo) && (acc_ext <= ulbs_pkg::SurrHi));
        end
      end else begin
        acc_d   = '0;
        rem_d   = 2'd0;
        class_d = ulbs_pkg::CLASS_NONE;
      end
    end
    if (lead) begin
      if (!in_byte_i[7]) begin
        deliver_en = 1'b1;
        dcp        = {{(ulbs_pkg::CpW-8){1'b0}}, in_byte_i};
      end else if (in_byte_i[7:5] == 3'b110) begin
        acc_d   = {{(ulbs_pkg::CpW-5){1'b0}}, in_byte_i[4:0]};
        rem_d   = 2'd1;
        class_d = ulbs_pkg::CLASS_2B;
      end else if (in_byte_i[7:4] == 4'b1110) begin
        acc_d   = {{(ulbs_pkg::CpW-4){1'b0}}, in_byte_i[3:0]};
        rem_d   = 2'd2;
        class_d = ulbs_pkg::CLASS_3B;
      end else if (in_byte_i[7:3] == 5'b11110) begin
        acc_d   = {{(ulbs_pkg::CpW-3){1'b0}}, in_byte_i[2:0]};
        rem_d   = 2'd3;
        class_d = ulbs_pkg::CLASS_4B;
      end
    end
  end

  // code point filter and re-encode
  assign is_skip  = first_q && ((dcp == ulbs_pkg::CpSpace) || (dcp == ulbs_pkg::CpTab) ||
                                (dcp == ulbs_pkg::CpCr));
  assign is_break = (dcp == ulbs_pkg::CpLf) || (dcp == ulbs_pkg::CpCr) ||
                    (dcp == ulbs_pkg::CpNel) || (dcp == ulbs_pkg::CpLs) ||
                    (dcp == ulbs_pkg::CpPs);
  assign printable = (dcp == ulbs_pkg::CpTab) ||
                     ((dcp >= ulbs_pkg::CpSpace) && (dcp <= ulbs_pkg::CpTilde)) ||
                     ((dcp >= ulbs_pkg::CpNbsp) && (dcp <= ulbs_pkg::CpBmpLo)) ||
                     ((dcp >= ulbs_pkg::CpPriv) && (dcp <= ulbs_pkg::CpBmpHi)) ||
                     ((dcp >= ulbs_pkg::Min4) && (dcp <= ulbs_pkg::CpMax));

  always_comb begin
    cmd_valid_o  = 1'b0;
    first_dec    = first_q;
    cmd_o.kind   = ulbs_pkg::KIND_TEXT;
    cmd_o.len_m1 = 2'd0;
    cmd_o.bytes  = '0;
    if (deliver_en && !is_skip) begin
      if (is_break) begin
        cmd_valid_o = 1'b1;
        cmd_o.kind  = ulbs_pkg::KIND_BREAK;
      end else if (printable) begin
        cmd_valid_o = 1'b1;
        first_dec   = 1'b0;
        if (dcp < ulbs_pkg::Min2) begin
          cmd_o.bytes[0] = dcp[7:0];
        end else if (dcp < ulbs_pkg::Min3) begin
          cmd_o.len_m1   = 2'd1;
          cmd_o.bytes[0] = {3'b110, dcp[10:6]};
          cmd_o.bytes[1] = {2'b10, dcp[5:0]};
        end else if (dcp < ulbs_pkg::Min4) begin
          cmd_o.len_m1   = 2'd2;
          cmd_o.bytes[0] = {4'b1110, dcp[15:12]};
          cmd_o.bytes[1] = {2'b10, dcp[11:6]};
          cmd_o.bytes[2] = {2'b10, dcp[5:0]};
        end else begin
          cmd_o.len_m1   = 2'd3;
          cmd_o.bytes[0] = {5'b11110, dcp[20:18]};
          cmd_o.bytes[1] = {2'b10, dcp[17:12]};
          cmd_o.bytes[2] = {2'b10, dcp[11:6]};
          cmd_o.bytes[3] = {2'b10, dcp[5:0]};
        end
      end
    end
  end

  assign first_d = stream_end_i ? 1'b1 : first_dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      rem_q   <= 2'd0;
      class_q <= ulbs_pkg::CLASS_NONE;
      first_q <= 1'b1;
    end else if (accept_i) begin
      first_q <= first_d;
      if (stream_end_i) begin
        acc_q   <= '0;
        rem_q   <= 2'd0;
        class_q <= ulbs_pkg::CLASS_NONE;
      end else begin
        acc_q   <= acc_d;
        rem_q   <= rem_d;
        class_q <= class_d;
      end
    end
  end

  a_rem_in_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != 2'd0) |-> ((class_q != ulbs_pkg::CLASS_NONE) && (rem_q <= class_q)))
    else $error("pending count exceeds sequence class");

  a_idle_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q == 2'd0) |-> ((acc_q == '0) && (class_q == ulbs_pkg::CLASS_NONE)))
    else $error("stale accumulator with no sequence pending");

endmodule
`default_nettype wire

// File: rtl/ulbs_cmd_fifo.sv
// Short command queue between the decoder and the byte emitter.
`default_nettype none
module ulbs_cmd_fifo #(
  parameter int unsigned Depth = ulbs_pkg::CmdDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  ulbs_pkg::ulbs_cmd_t     wdata_i,
  input  wire logic               pop_i,
  output ulbs_pkg::ulbs_cmd_t     rdata_o,
  output logic                    full_o,
  output logic                    empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  ulbs_pkg::ulbs_cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt)
    else $error("command queue over-filled");

endmodule
`default_nettype wire

// File: rtl/ulbs_back.sv
// Back end: expands commands into output bytes, one beat per cycle unless the output is stalled.
`default_nettype none
module ulbs_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [ulbs_pkg::IndentW-1:0]  indent_width_i,
  input  ulbs_pkg::ulbs_cmd_t                head_i,
  input  wire logic                          head_empty_i,
  output logic                               head_pop_o,
  output logic [7:0]                         out_byte_o,
  output logic                               last_of_run_o,
  output logic                               empty_o,
  input  wire logic                          pop_i
);

  ulbs_pkg::ulbs_cmd_t          cmd_q, cur;
  logic                         active_q;
  logic [ulbs_pkg::RunIdxW-1:0] idx_q, cur_idx, cur_final, act_final;
  logic                         out_valid_q;
  logic [7:0]                   out_byte_q, cur_byte;
  logic                         out_last_q;
  logic                         out_adv, src_valid, fire, cur_last;

  assign out_adv   = !out_valid_q || pop_i;
  assign src_valid = active_q || !head_empty_i;
  assign fire      = out_adv && src_valid;
  assign cur       = active_q ? cmd_q : head_i;
  assign cur_idx   = active_q ? idx_q : '0;
  assign head_pop_o = out_adv && !active_q && !head_empty_i;

  always_comb begin
    unique case (cur.kind)
      ulbs_pkg::KIND_BREAK: begin
        cur_final = indent_width_i;
        cur_byte  = (cur_idx == '0) ? ulbs_pkg::ByteLf : ulbs_pkg::ByteSpace;
      end
      default: begin
        cur_final = {{(ulbs_pkg::RunIdxW-2){1'b0}}, cur.len_m1};
        cur_byte  = cur.bytes[cur_idx[1:0]];
      end
    endcase
  end

  assign cur_last  = (cur_idx == cur_final);
  assign act_final = (cmd_q.kind == ulbs_pkg::KIND_BREAK) ? indent_width_i :
                     {{(ulbs_pkg::RunIdxW-2){1'b0}}, cmd_q.len_m1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= src_valid;
      if (fire) begin
        active_q <= !cur_last;
        idx_q    <= cur_idx + ulbs_pkg::RunIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      cmd_q      <= cur;
      out_byte_q <= cur_byte;
      out_last_q <= cur_last;
    end
  end

  assign empty_o       = !out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> ((idx_q != '0) && (idx_q <= act_final)))
    else $error("run index outside command");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> (out_valid_q && $stable(out_byte_q) && $stable(active_q)))
    else $error("emitter moved while output beat stalled");

endmodule
`default_nettype wire

// File: rtl/utf8_literal_block_sanitizer.sv
// Top level of the UTF-8 literal block sanitizer.
// Bytes enter through push/full and are decoded, validated and filtered combinationally; each
// accepted byte yields at most one command into a CmdDepth-entry queue. The emitter drains the
// queue at one output beat per cycle through empty/pop unless pop stalls it, so a byte that
// makes one character is taken every cycle; a multibyte character yields one output byte per
// encoded byte, and a line break yields an LF and then indent_width spaces. The input stalls
// (full) once the queue has filled behind a long run. The indent register should be written only
// while the block is idle.
`default_nettype none
module utf8_literal_block_sanitizer #(
  parameter int unsigned CmdDepth = ulbs_pkg::CmdDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          indent_width_we_i,
  input  wire logic [ulbs_pkg::IndentW-1:0]  indent_width_i,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    in_byte_i,
  input  wire logic                          stream_end_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [7:0]                         out_byte_o,
  output logic                               last_of_run_o
);

  logic [ulbs_pkg::IndentW-1:0] indent_width_q;
  ulbs_pkg::ulbs_cmd_t          f_cmd, q_head;
  logic                         f_cmd_valid, accept, q_empty, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      indent_width_q <= '0;
    end else if (indent_width_we_i) begin
      indent_width_q <= indent_width_i;
    end
  end

  assign accept = push && !full;

  ulbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_byte_i),
    .stream_end_i (stream_end_i),
    .cmd_o        (f_cmd),
    .cmd_valid_o  (f_cmd_valid)
  );

  ulbs_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && f_cmd_valid),
    .wdata_i (f_cmd),
    .pop_i   (q_pop),
    .rdata_o (q_head),
    .full_o  (full),
    .empty_o (q_empty)
  );

  ulbs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .indent_width_i (indent_width_q),
    .head_i         (q_head),
    .head_empty_i   (q_empty),
    .head_pop_o     (q_pop),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .empty_o        (empty),
    .pop_i          (pop)
  );

endmodule
`default_nettype wire
